>>> rtl/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg
// Types and constants shared by the IKE-over-TCP stream deframer.
// ----------------------------------------------------------------------------
package itd_pkg;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_EMPTY      = 3'd1,
    KIND_BAD_PREFIX = 3'd2,
    KIND_BAD_MARKER = 3'd3,
    KIND_BAD_LENGTH = 3'd4
  } result_kind_e;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   payload;
    logic         last;
  } result_t;

  localparam logic [15:0] MinFrameLen   = 16'd6;
  localparam int unsigned PrefixLen     = 6;
  localparam logic [2:0]  PrefixLastIdx = 3'(PrefixLen - 1);
  localparam logic [2:0]  MarkerLastIdx = 3'd3;

  // "IKETCP" stream prefix
  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h49;
      3'd1:    b = 8'h4b;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h43;
      3'd5:    b = 8'h50;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/itd_byte_if.sv
// ----------------------------------------------------------------------------
// itd_byte_if
// Valid/ready channel carrying one byte of the TCP stream.
// ----------------------------------------------------------------------------
interface itd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> rtl/itd_result_if.sv
// ----------------------------------------------------------------------------
// itd_result_if
// Valid/ready channel carrying one deframer result.
// ----------------------------------------------------------------------------
interface itd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] payload_byte;
  logic       message_last;

  modport source (output valid, output result_kind, output payload_byte,
                  output message_last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input message_last, output ready);
endinterface

>>> rtl/ike_tcp_stream_deframer.sv
// ----------------------------------------------------------------------------
// ike_tcp_stream_deframer
// IKE-over-TCP stream deframer: optional "IKETCP" prefix check, then frames
// of length, zero marker and message; emits message bytes, empty-message results or error codes.
// ----------------------------------------------------------------------------
// a result is formed combinationally and registered in the output buffer
// throughput: one byte per cycle while input ready is high; the parser updates
// its state in the cycle of acceptance and a two-entry result buffer absorbs
// output stalls; input ready drops only when both result entries are occupied
// reset: asynchronous, active low; clears framing state and sets
// expect_prefix to 1
// ----------------------------------------------------------------------------
module ike_tcp_stream_deframer
  import itd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  itd_byte_if.sink     byte_i,
  itd_result_if.source result_o
);

  logic    expect_prefix_q;
  logic    take;
  logic    buf_ready;
  logic    res_valid;
  result_t res;
  result_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_prefix_q <= 1'b1;
    end else if (cfg_we_i) begin
      expect_prefix_q <= cfg_wdata_i;
    end
  end

  assign byte_i.ready = buf_ready;
  assign take         = byte_i.valid && buf_ready;

  itd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .byte_i          (byte_i.stream_byte),
    .expect_prefix_i (expect_prefix_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  itd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (result_o.valid),
    .pop_ready_i (result_o.ready),
    .data_o      (out_data)
  );

  assign result_o.result_kind  = out_data.kind;
  assign result_o.payload_byte = out_data.payload;
  assign result_o.message_last = out_data.last;

  a_result_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> take)
    else $error("result without an accepted request");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.result_kind != KIND_PAYLOAD)
      |-> (result_o.payload_byte == 8'h00))
    else $error("non-payload result carries data");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> byte_i.ready)
    else $error("input stalled with empty output");

endmodule

>>> rtl/itd_parser.sv
// ----------------------------------------------------------------------------
// itd_parser
// Framing state machine: prefix check, length, marker and payload phases.
// ----------------------------------------------------------------------------
module itd_parser
  import itd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       expect_prefix_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_FRAME,
    PH_PREFIX,
    PH_LEN_LO,
    PH_MARKER,
    PH_PAYLOAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        prefix_done_q, prefix_done_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] payload_left_q, payload_left_d;
  logic        failed_q, failed_d;
  logic [15:0] frame_len;

  assign frame_len = {length_high_q, byte_i};

  always_comb begin
    phase_d        = phase_q;
    prefix_done_d  = prefix_done_q;
    byte_index_d   = byte_index_q;
    length_high_d  = length_high_q;
    payload_left_d = payload_left_q;
    failed_d       = failed_q;
    res_valid_o    = 1'b0;
    res_o          = '{kind: KIND_PAYLOAD, payload: 8'h00, last: 1'b0};

    if (take_i && !failed_q) begin
      unique case (phase_q)
        PH_FRAME: begin
          if (expect_prefix_i && !prefix_done_q) begin
            if (byte_i != prefix_byte(3'd0)) begin
              failed_d    = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_BAD_PREFIX;
            end else begin
              byte_index_d = 3'd1;
              phase_d      = PH_PREFIX;
            end
          end else begin
            length_high_d = byte_i;
            phase_d       = PH_LEN_LO;
          end
        end
        PH_PREFIX: begin
          if (byte_i != prefix_byte(byte_index_q)) begin
            failed_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_PREFIX;
          end else if (byte_index_q >= PrefixLastIdx) begin
            prefix_done_d = 1'b1;
            byte_index_d  = 3'd0;
            phase_d       = PH_FRAME;
          end else begin
            byte_index_d = byte_index_q + 3'd1;
          end
        end
        PH_LEN_LO: begin
          // a length counts its own two bytes and the marker
          if (frame_len < MinFrameLen) begin
            failed_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_LENGTH;
          end else begin
            payload_left_d = frame_len - MinFrameLen;
            byte_index_d   = 3'd0;
            phase_d        = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (byte_i != 8'h00) begin
            failed_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_MARKER;
          end else if (byte_index_q >= MarkerLastIdx) begin
            byte_index_d = 3'd0;
            if (payload_left_q == 16'd0) begin
              phase_d     = PH_FRAME;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EMPTY;
              res_o.last  = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            byte_index_d = byte_index_q + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_PAYLOAD;
          res_o.payload  = byte_i;
          res_o.last     = (payload_left_q <= 16'd1);
          payload_left_d = (payload_left_q != 16'd0) ? payload_left_q - 16'd1 : 16'd0;
          if (payload_left_d == 16'd0) begin
            phase_d = PH_FRAME;
          end
        end
        default: begin
          phase_d      = PH_FRAME;
          byte_index_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_FRAME;
      prefix_done_q  <= 1'b0;
      byte_index_q   <= 3'd0;
      length_high_q  <= 8'h00;
      payload_left_q <= 16'd0;
      failed_q       <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      prefix_done_q  <= prefix_done_d;
      byte_index_q   <= byte_index_d;
      length_high_q  <= length_high_d;
      payload_left_q <= payload_left_d;
      failed_q       <= failed_d;
    end
  end

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q)
    else $error("failed flag cleared without reset");

  a_silent_after_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !res_valid_o)
    else $error("result produced after a framing error");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (payload_left_q != 16'd0))
    else $error("payload phase with nothing left");

  a_error_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind != KIND_PAYLOAD && res_o.kind != KIND_EMPTY) |=> failed_q)
    else $error("error result did not stop the block");

endmodule

>>> rtl/itd_out_buf.sv
// ----------------------------------------------------------------------------
// itd_out_buf
// Result register with a skid entry, so the input side keeps running while a
// result waits on the output handshake.
// ----------------------------------------------------------------------------
module itd_out_buf
  import itd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  result_t main_q, skid_q;
  logic    main_vld_q, skid_vld_q;
  logic    pop;

  assign pop     = main_vld_q && pop_ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push_i) begin
        if (main_vld_q && !pop) begin
          skid_vld_q <= 1'b1;
        end else begin
          main_vld_q <= 1'b1;
        end
      end else if (pop) begin
        main_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_vld_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("request pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && pop) |=> (main_vld_q && !skid_vld_q))
    else $error("skid entry lost on pop");

endmodule
